// ===== hdl/rgb_two_by_two_box_downsample_assert.svh =====
// Assertion macros for the two-by-two box downsampler.
`ifndef RGB_TWO_BY_TWO_BOX_DOWNSAMPLE_ASSERT_SVH
`define RGB_TWO_BY_TWO_BOX_DOWNSAMPLE_ASSERT_SVH

`ifndef ASSERT_OFF
`define RGBBOX_ASSERT_IMP(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error("rgbbox assertion failed");
`define RGBBOX_ASSERT_NEXT(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error("rgbbox assertion failed");
`else
`define RGBBOX_ASSERT_IMP(label, clk, rst, ante, cons)
`define RGBBOX_ASSERT_NEXT(label, clk, rst, ante, cons)
`endif

`endif

// ===== hdl/rgbbox_pkg.sv =====
// Package with constants and register codes of the box downsampler.
package rgbbox_pkg;

   localparam int CFG_DATA_W = 11;
   localparam int MAX_WIDTH_DEF = 1024;
   localparam int MAX_HEIGHT_DEF = 1024;
   localparam int PIXEL_W = 8;
   localparam int MIN_SIZE = 2;
   localparam logic [PIXEL_W-1:0] ALPHA_OPAQUE = 8'hFF;
   localparam logic [CFG_DATA_W-1:0] IMAGE_WIDTH_RESET = 11'd512;
   localparam logic [CFG_DATA_W-1:0] IMAGE_HEIGHT_RESET = 11'd512;

   typedef enum logic [0:0] {
      REG_IMAGE_WIDTH  = 1'b0,
      REG_IMAGE_HEIGHT = 1'b1
   } reg_index_type;

endpackage

// ===== hdl/rgb_two_by_two_box_downsample.sv =====
// Top level of the RGB two-by-two box downsampler.
//
//   channel  | direction | handshake              | payload
//   req_     | in        | req_tvalid/req_tready  | req_tdata: red, green, blue
//   rsp_     | out       | rsp_tvalid/rsp_tready  | rsp_tdata: r, g, b, alpha; tlast
//   csr_     | in        | csr_wr_en              | csr_index, csr_wdata
//
// One pixel is accepted per clock while req_tready is high; a result appears in
// the cycle after the right-hand pixel of an odd row's pair is accepted.
// The line RAM sees at most one access per pixel (a read at the left pixel of
// an odd-row pair, a write at the right pixel of an even-row pair).
// req_tready drops only in reset or while a result waits and rsp_tready is low.
// Synchronous reset clears counters and the output valid, sets sizes to 512; no RAM clear.
`include "rgb_two_by_two_box_downsample_assert.svh"

module rgb_two_by_two_box_downsample #(
   parameter int MaxWidth = rgbbox_pkg::MAX_WIDTH_DEF,
   parameter int MaxHeight = rgbbox_pkg::MAX_HEIGHT_DEF
) (
   input  logic                              clock,
   input  logic                              reset,
   input  logic                              req_tvalid,
   output logic                              req_tready,
   input  logic [23:0]                       req_tdata,   // in_red, in_green, in_blue
   output logic                              rsp_tvalid,
   input  logic                              rsp_tready,
   output logic [31:0]                       rsp_tdata,   // out_red, out_green, out_blue, out_alpha
   output logic                              rsp_tlast,
   input  logic                              csr_wr_en,
   input  logic [0:0]                        csr_index,
   input  logic [rgbbox_pkg::CFG_DATA_W-1:0] csr_wdata
);

   localparam int CfgW = rgbbox_pkg::CFG_DATA_W;
   localparam int PixW = rgbbox_pkg::PIXEL_W;
   localparam int ColBits = (MaxWidth > 2) ? $clog2(MaxWidth) : 1;
   localparam int RowBits = (MaxHeight > 2) ? $clog2(MaxHeight) : 1;
   localparam int WBits = (CfgW > $clog2(MaxWidth + 1)) ? CfgW : $clog2(MaxWidth + 1);
   localparam int HBits = (CfgW > $clog2(MaxHeight + 1)) ? CfgW : $clog2(MaxHeight + 1);
   localparam int LineDepth = (MaxWidth + 1) / 2;
   localparam int AddrBits = (LineDepth > 1) ? $clog2(LineDepth) : 1;
   localparam int SumW = PixW + 1;
   localparam int TotW = PixW + 2;
   localparam int LineW = 3 * SumW;

   logic [CfgW-1:0]    width_ff, width_in;
   logic [CfgW-1:0]    height_ff, height_in;
   logic [ColBits-1:0] col_ff, col_in;
   logic [RowBits-1:0] row_ff, row_in;
   logic [3*PixW-1:0]  left_ff, left_in;
   logic               rsp_valid_ff, rsp_valid_in;
   logic [3*PixW-1:0]  rsp_rgb_ff, rsp_rgb_in;
   logic               rsp_last_ff, rsp_last_in;

   logic [WBits-1:0]   width_ext, width_eff, last_col, col_next;
   logic [HBits-1:0]   height_ext, height_eff, last_row, row_next;
   logic               req_accept, odd_col, odd_row, emit, col_wrap, row_wrap;
   logic [LineW-1:0]   pair_sum, above;
   logic [AddrBits-1:0] line_addr;
   logic [3*PixW-1:0]  avg_rgb;

   assign req_tready = !reset && (!rsp_valid_ff || rsp_tready);
   assign req_accept = req_tvalid && req_tready;
   assign odd_col = col_ff[0];
   assign odd_row = row_ff[0];
   assign emit = odd_col && odd_row;

   // Clamp sizes to the legal range.
   always_comb begin
      width_ext = WBits'(width_ff);
      height_ext = HBits'(height_ff);
      if (width_ext < WBits'(rgbbox_pkg::MIN_SIZE)) begin
         width_eff = WBits'(rgbbox_pkg::MIN_SIZE);
      end else if (width_ext > WBits'(MaxWidth)) begin
         width_eff = WBits'(MaxWidth);
      end else begin
         width_eff = width_ext;
      end
      if (height_ext < HBits'(rgbbox_pkg::MIN_SIZE)) begin
         height_eff = HBits'(rgbbox_pkg::MIN_SIZE);
      end else if (height_ext > HBits'(MaxHeight)) begin
         height_eff = HBits'(MaxHeight);
      end else begin
         height_eff = height_ext;
      end
      last_col = (width_eff & ~WBits'(1)) - WBits'(1);
      last_row = (height_eff & ~HBits'(1)) - HBits'(1);
      col_next = WBits'(col_ff) + WBits'(1);
      row_next = HBits'(row_ff) + HBits'(1);
      col_wrap = col_next >= width_eff;
      row_wrap = row_next >= height_eff;
   end

   // Horizontal pair sums and 2x2 averages, channel by channel.
   always_comb begin
      for (int c = 0; c < 3; c++) begin
         pair_sum[c*SumW +: SumW] = SumW'(req_tdata[c*PixW +: PixW])
                                  + SumW'(left_ff[c*PixW +: PixW]);
         avg_rgb[c*PixW +: PixW] = PixW'((TotW'(pair_sum[c*SumW +: SumW])
                                        + TotW'(above[c*SumW +: SumW])) >> 2);
      end
   end

   assign line_addr = AddrBits'(col_ff >> 1);

   rgbbox_line_ram #(
      .DataWidth(LineW),
      .Depth(LineDepth)
   ) u_line_ram (
      .clock  (clock),
      .wr_en  (req_accept && odd_col && !odd_row),
      .wr_addr(line_addr),
      .wr_data(pair_sum),
      .rd_en  (req_accept && !odd_col && odd_row),
      .rd_addr(line_addr),
      .rd_data(above)
   );

   always_comb begin
      width_in = width_ff;
      height_in = height_ff;
      if (csr_wr_en) begin
         unique case (rgbbox_pkg::reg_index_type'(csr_index))
            rgbbox_pkg::REG_IMAGE_WIDTH:  width_in = csr_wdata;
            rgbbox_pkg::REG_IMAGE_HEIGHT: height_in = csr_wdata;
            default: ;
         endcase
      end

      col_in = col_ff;
      row_in = row_ff;
      left_in = left_ff;
      if (req_accept) begin
         if (!odd_col) begin
            left_in = req_tdata;
         end
         if (col_wrap) begin
            col_in = '0;
            row_in = row_wrap ? '0 : RowBits'(row_next);
         end else begin
            col_in = ColBits'(col_next);
         end
      end

      rsp_valid_in = rsp_valid_ff;
      rsp_rgb_in = rsp_rgb_ff;
      rsp_last_in = rsp_last_ff;
      if (req_tready) begin
         rsp_valid_in = req_accept && emit;
      end
      if (req_accept && emit) begin
         rsp_rgb_in = avg_rgb;
         rsp_last_in = (WBits'(col_ff) == last_col) && (HBits'(row_ff) == last_row);
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         width_ff <= rgbbox_pkg::IMAGE_WIDTH_RESET;
         height_ff <= rgbbox_pkg::IMAGE_HEIGHT_RESET;
         col_ff <= '0;
         row_ff <= '0;
         left_ff <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         width_ff <= width_in;
         height_ff <= height_in;
         col_ff <= col_in;
         row_ff <= row_in;
         left_ff <= left_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      rsp_rgb_ff <= rsp_rgb_in;
      rsp_last_ff <= rsp_last_in;
   end

   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata = {rgbbox_pkg::ALPHA_OPAQUE, rsp_rgb_ff};
   assign rsp_tlast = rsp_last_ff;

   `RGBBOX_ASSERT_NEXT(a_emit_gives_result, clock, reset, req_accept && emit, rsp_tvalid)
   `RGBBOX_ASSERT_NEXT(a_no_spurious_result, clock, reset,
      req_accept && !emit && rsp_tready, !rsp_tvalid)
   `RGBBOX_ASSERT_IMP(a_col_in_range, clock, reset, 1'b1, WBits'(col_ff) < WBits'(MaxWidth))

endmodule

// ===== hdl/rgbbox_line_ram.sv =====
// Generic single-write, single-read RAM with registered read data.
module rgbbox_line_ram #(
   parameter int DataWidth = 27,
   parameter int Depth = 512,
   localparam int AddrBits = (Depth > 1) ? $clog2(Depth) : 1
) (
   input  logic                 clock,
   input  logic                 wr_en,
   input  logic [AddrBits-1:0]  wr_addr,
   input  logic [DataWidth-1:0] wr_data,
   input  logic                 rd_en,
   input  logic [AddrBits-1:0]  rd_addr,
   output logic [DataWidth-1:0] rd_data
);

   logic [DataWidth-1:0] mem_ff [Depth];
   logic [DataWidth-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      if (rd_en) begin
         rd_data_ff <= mem_ff[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule
